/* src/mpag_pkg.sv */
package mpag_pkg;

   localparam int COORD_W  = 6;
   localparam int SRC_W    = 24;
   localparam int DST_W    = 14;
   localparam int STRIDE_W = 5;
   localparam int MB_IDX_W = 13;   // v*W+h never exceeds 64*63+63
   localparam int WH_W     = 12;   // W*H of two 6-bit values
   localparam int STEP_W   = 4;

   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   localparam logic [STRIDE_W-1:0] STRIDE_LUMA   = 5'd16;
   localparam logic [STRIDE_W-1:0] STRIDE_CHROMA = 5'd8;

   typedef enum logic [1:0] {
      CSR_FETCH_ENABLE    = 2'd0,
      CSR_FRAME_MB_HEIGHT = 2'd1,
      CSR_FRAME_MB_WIDTH  = 2'd2,
      CSR_FRAME_BASE      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] mb_col;
      logic [COORD_W-1:0] mb_row;
   } req_type;

   typedef struct packed {
      logic                copy_valid;
      logic [1:0]          plane;
      logic [SRC_W-1:0]    src_addr;
      logic [DST_W-1:0]    dst_addr;
      logic [STRIDE_W-1:0] row_stride;
      logic [COORD_W-1:0]  col_echo;
      logic [COORD_W-1:0]  row_echo;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic               fetch_enable;
      logic [COORD_W-1:0] frame_mb_height;
      logic [COORD_W-1:0] frame_mb_width;
      logic [SRC_W-1:0]   frame_base;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_WH,
      MUL_VW,
      MUL_RECIP,
      MUL_QL
   } mul_op_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD_WH,
      DP_PICK,
      DP_SUM_M,
      DP_REM,
      DP_EMIT_Y,
      DP_EMIT_U,
      DP_EMIT_V,
      DP_EMIT_NONE
   } dp_op_type;

   typedef enum logic [2:0] {
      J_NEXT,
      J_DONE,
      J_NOPEND,
      J_KMORE,
      J_PEND_ELSE_DONE
   } jmp_type;

   typedef struct packed {
      mul_op_type        mul_op;
      dp_op_type         dp_op;
      jmp_type           jmp;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic pend_none;
      logic k_last;
   } dp_status_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // program addresses
   localparam logic [STEP_W-1:0] STEP_MWH   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LWH   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_PICK  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MVW   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SUMM  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MRC   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MQL   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_REM   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_EY    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EU    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EV    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_EMPTY = 4'd11;

   localparam ucode_type UCODE_NOP = '{MUL_HOLD, DP_NOP, J_DONE, STEP_MWH};

   function automatic ucode_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = UCODE_NOP;
      case (step)
         STEP_MWH:   w = '{MUL_WH,    DP_NOP,       J_NEXT,           STEP_MWH};
         STEP_LWH:   w = '{MUL_HOLD,  DP_LOAD_WH,   J_NOPEND,         STEP_EMPTY};
         STEP_PICK:  w = '{MUL_HOLD,  DP_PICK,      J_NEXT,           STEP_MWH};
         STEP_MVW:   w = '{MUL_VW,    DP_NOP,       J_NEXT,           STEP_MWH};
         STEP_SUMM:  w = '{MUL_HOLD,  DP_SUM_M,     J_NEXT,           STEP_MWH};
         STEP_MRC:   w = '{MUL_RECIP, DP_NOP,       J_NEXT,           STEP_MWH};
         STEP_MQL:   w = '{MUL_QL,    DP_NOP,       J_NEXT,           STEP_MWH};
         STEP_REM:   w = '{MUL_HOLD,  DP_REM,       J_NEXT,           STEP_MWH};
         STEP_EY:    w = '{MUL_HOLD,  DP_EMIT_Y,    J_KMORE,          STEP_EY};
         STEP_EU:    w = '{MUL_HOLD,  DP_EMIT_U,    J_NEXT,           STEP_MWH};
         STEP_EV:    w = '{MUL_HOLD,  DP_EMIT_V,    J_PEND_ELSE_DONE, STEP_PICK};
         STEP_EMPTY: w = '{MUL_HOLD,  DP_EMIT_NONE, J_DONE,           STEP_MWH};
         default:    w = UCODE_NOP;
      endcase
      return w;
   endfunction

endpackage

/* src/mpag_sequencer.sv */
module mpag_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  mpag_pkg::dp_status_type status,
   output mpag_pkg::ucode_type    ctrl,
   output logic                   busy
);
   import mpag_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;

   assign word = ucode_word(step_ff);

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = SEQ_RUN;
               step_in  = STEP_MWH;
            end
         end
         SEQ_RUN: begin
            case (word.jmp)
               J_NEXT:  step_in = step_ff + 1'b1;
               J_DONE:  state_in = SEQ_IDLE;
               J_NOPEND: begin
                  step_in = status.pend_none ? word.target : step_ff + 1'b1;
               end
               J_KMORE: begin
                  step_in = status.k_last ? step_ff + 1'b1 : word.target;
               end
               J_PEND_ELSE_DONE: begin
                  if (status.pend_none) begin
                     state_in = SEQ_IDLE;
                  end else begin
                     step_in = word.target;
                  end
               end
               default: state_in = SEQ_IDLE;
            endcase
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = 1'b0;
      ctrl = UCODE_NOP;
      case (state_ff)
         SEQ_IDLE: begin
            busy = 1'b0;
            ctrl = UCODE_NOP;
         end
         SEQ_RUN: begin
            busy = 1'b1;
            ctrl = word;
         end
         default: begin
            busy = 1'b0;
            ctrl = UCODE_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= STEP_MWH;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* src/mpag_datapath.sv */
module mpag_datapath #(
   parameter int LINE_BUFFER_MBS = 64,
   parameter int ADDR_BITS       = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  mpag_pkg::req_type       req,
   input  mpag_pkg::cfg_type       cfg,
   input  mpag_pkg::ucode_type     ctrl,
   output mpag_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output mpag_pkg::rsp_type       rsp
);
   import mpag_pkg::*;

   localparam int R_W = (LINE_BUFFER_MBS > 1) ? $clog2(LINE_BUFFER_MBS) : 1;
   // m mod L via ceil reciprocal; exact for m < 2^13 and L <= 256
   localparam int RECIP_SHIFT = 22;
   localparam int MUL_A_W     = MB_IDX_W;
   localparam int MUL_B_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << RECIP_SHIFT) + LINE_BUFFER_MBS - 1) / LINE_BUFFER_MBS;
   localparam logic [MUL_B_W-1:0] RECIP   = MUL_B_W'(RECIP_VAL);
   localparam logic [MUL_B_W-1:0] LB_MBS  = MUL_B_W'(LINE_BUFFER_MBS);
   localparam int KEEP_BITS = (ADDR_BITS < SRC_W) ? ADDR_BITS : SRC_W;
   localparam logic [SRC_W-1:0] AMASK = SRC_W'((64'd1 << KEEP_BITS) - 64'd1);

   logic [COORD_W-1:0]  h_ff, h_in, v_ff, v_in;
   logic [COORD_W-1:0]  hh_ff, hh_in, vv_ff, vv_in;
   logic [3:0]          pend_ff, pend_in;
   logic [1:0]          k_ff, k_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [WH_W-1:0]     wh_ff, wh_in;
   logic [SRC_W-1:0]    ubase_ff, ubase_in;
   logic [MB_IDX_W-1:0] m_ff, m_in;
   logic [R_W-1:0]      r_ff, r_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [3:0]          take;
   logic [COORD_W:0]    h_p1, v_p1;
   logic                w_nz, h_nz;
   logic [15:0]         dst_y, dst_c;
   logic [MB_IDX_W:0]   wh_m;

   // candidate neighbours, in emission order
   always_comb begin
      h_p1 = {1'b0, req.mb_col} + 1'b1;
      v_p1 = {1'b0, req.mb_row} + 1'b1;
      w_nz = cfg.frame_mb_width != '0;
      h_nz = cfg.frame_mb_height != '0;
      take[0] = req.mb_col == '0 && req.mb_row == '0 && w_nz && h_nz;
      take[1] = req.mb_row == '0 && h_p1 < {1'b0, cfg.frame_mb_width} && h_nz;
      take[2] = req.mb_col == '0 && w_nz && v_p1 < {1'b0, cfg.frame_mb_height};
      take[3] = h_p1 < {1'b0, cfg.frame_mb_width}
                && v_p1 < {1'b0, cfg.frame_mb_height};
      take    = cfg.fetch_enable ? take : 4'b0000;
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.mul_op)
         MUL_WH: begin
            mul_a = MUL_A_W'(cfg.frame_mb_height);
            mul_b = MUL_B_W'(cfg.frame_mb_width);
         end
         MUL_VW: begin
            mul_a = MUL_A_W'(vv_ff);
            mul_b = MUL_B_W'(cfg.frame_mb_width);
         end
         MUL_RECIP: begin
            mul_a = m_ff;
            mul_b = RECIP;
         end
         MUL_QL: begin
            mul_a = prod_ff[RECIP_SHIFT +: MUL_A_W];
            mul_b = LB_MBS;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      if (ctrl.mul_op == MUL_HOLD) begin
         prod_in = prod_ff;
      end else begin
         prod_in = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
      end
   end

   always_comb begin
      dst_y = (16'(r_ff) << 8) | (16'(k_ff[1]) << 7) | (16'(k_ff[0]) << 3);
      dst_c = 16'(r_ff) << 6;
      wh_m  = (MB_IDX_W+1)'(wh_ff) + (MB_IDX_W+1)'(m_ff);
   end

   always_comb begin
      h_in         = h_ff;
      v_in         = v_ff;
      hh_in        = hh_ff;
      vv_in        = vv_ff;
      pend_in      = pend_ff;
      k_in         = k_ff;
      wh_in        = wh_ff;
      ubase_in     = ubase_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_in.col_echo = h_ff;
      rsp_in.row_echo = v_ff;

      if (accept) begin
         h_in    = req.mb_col;
         v_in    = req.mb_row;
         pend_in = take;
      end

      case (ctrl.dp_op)
         DP_LOAD_WH: begin
            wh_in    = prod_ff[WH_W-1:0];
            ubase_in = cfg.frame_base + (SRC_W'(prod_ff[WH_W-1:0]) << 8);
         end
         DP_PICK: begin
            k_in    = 2'd0;
            pend_in = pend_ff & (pend_ff - 1'b1);
            if (pend_ff[0]) begin
               hh_in = h_ff;
               vv_in = v_ff;
            end else if (pend_ff[1]) begin
               hh_in = h_ff + 1'b1;
               vv_in = v_ff;
            end else if (pend_ff[2]) begin
               hh_in = h_ff;
               vv_in = v_ff + 1'b1;
            end else begin
               hh_in = h_ff + 1'b1;
               vv_in = v_ff + 1'b1;
            end
         end
         DP_SUM_M: m_in = prod_ff[MB_IDX_W-1:0] + MB_IDX_W'(hh_ff);
         DP_REM:   r_in = R_W'(m_ff - prod_ff[MB_IDX_W-1:0]);
         DP_EMIT_Y: begin
            k_in              = k_ff + 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_in.copy_valid = 1'b1;
            rsp_in.plane      = PLANE_Y;
            rsp_in.src_addr   = (cfg.frame_base + (SRC_W'(m_ff) << 8)
                                 + (SRC_W'(k_ff) << 6)) & AMASK;
            rsp_in.dst_addr   = dst_y[DST_W-1:0];
            rsp_in.row_stride = STRIDE_LUMA;
            rsp_in.last       = 1'b0;
         end
         DP_EMIT_U: begin
            rsp_valid_in      = 1'b1;
            rsp_in.copy_valid = 1'b1;
            rsp_in.plane      = PLANE_U;
            rsp_in.src_addr   = (ubase_ff + (SRC_W'(m_ff) << 6)) & AMASK;
            rsp_in.dst_addr   = dst_c[DST_W-1:0];
            rsp_in.row_stride = STRIDE_CHROMA;
            rsp_in.last       = 1'b0;
         end
         DP_EMIT_V: begin
            // V plane sits a quarter luma size past U
            rsp_valid_in      = 1'b1;
            rsp_in.copy_valid = 1'b1;
            rsp_in.plane      = PLANE_V;
            rsp_in.src_addr   = (ubase_ff + (SRC_W'(wh_m) << 6)) & AMASK;
            rsp_in.dst_addr   = dst_c[DST_W-1:0];
            rsp_in.row_stride = STRIDE_CHROMA;
            rsp_in.last       = pend_ff == '0;
         end
         DP_EMIT_NONE: begin
            rsp_valid_in      = 1'b1;
            rsp_in.copy_valid = 1'b0;
            rsp_in.plane      = '0;
            rsp_in.src_addr   = '0;
            rsp_in.dst_addr   = '0;
            rsp_in.row_stride = '0;
            rsp_in.last       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      h_ff     <= h_in;
      v_ff     <= v_in;
      hh_ff    <= hh_in;
      vv_ff    <= vv_in;
      prod_ff  <= prod_in;
      wh_ff    <= wh_in;
      ubase_ff <= ubase_in;
      m_ff     <= m_in;
      r_ff     <= r_in;
      rsp_ff   <= rsp_in;
   end

   assign status.pend_none = pend_ff == '0;
   assign status.k_last    = k_ff == 2'd3;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp              = rsp_ff;

endmodule

/* src/macroblock_prefetch_address_generator_core.sv */
// channel   ports                          handshake
// -------   ----------------------------   ------------------------------------
// request   start, busy, req_data          beat taken when start && !busy
// response  rsp_valid, rsp_data            one-cycle strobe, receiver can't stall
// csr       csr_we, csr_index, csr_wdata   write when csr_we, no wait
//
// One item keeps busy high while the sequencer runs, with n fetched macroblocks
// (n = 0..4); busy rises the cycle after start. Per macroblock, address setup on
// the one shared multiplier (m = v*W+h and m mod LINE_BUFFER_MBS) comes first,
// then the descriptors. Each descriptor is registered and shows in the cycle
// after its microcode step.
// Reset is synchronous and clears config to zero; no clearing pass.
module macroblock_prefetch_address_generator_core #(
   parameter int LINE_BUFFER_MBS = 64,
   parameter int ADDR_BITS       = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mpag_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output mpag_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  mpag_pkg::csr_index_type        csr_index,
   input  logic [mpag_pkg::SRC_W-1:0]     csr_wdata
);
   import mpag_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   ucode_type     ctrl;
   dp_status_type status;
   logic          accept;

   assign accept = start & ~busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FETCH_ENABLE:    cfg_in.fetch_enable    = csr_wdata[0];
            CSR_FRAME_MB_HEIGHT: cfg_in.frame_mb_height = csr_wdata[COORD_W-1:0];
            CSR_FRAME_MB_WIDTH:  cfg_in.frame_mb_width  = csr_wdata[COORD_W-1:0];
            CSR_FRAME_BASE:      cfg_in.frame_base      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpag_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   mpag_datapath #(
      .LINE_BUFFER_MBS (LINE_BUFFER_MBS),
      .ADDR_BITS       (ADDR_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cfg       (cfg_ff),
      .ctrl      (ctrl),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

`ifndef SYNTHESIS
   a_rsp_inside_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response beat outside an item");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("sequencer still running after last beat");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.copy_valid |-> rsp_data.last)
      else $error("empty response not marked last");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not start the sequencer");
`endif

endmodule
